// ===== rtl/rcm_pkg.sv =====
// shared constants, types and table functions of the reference coordinate mapper
package rcm_pkg;

    localparam int Q_BITS = 30;
    localparam int IN_W = 17;
    localparam int OUT_W = 19;
    localparam int MODE_W = 4;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 64;
    // fraction bits of the port formats, tied to IN_W and OUT_W
    localparam int FRAC_BITS = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic [MODE_W-1:0] MODE_IDENT   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_POLAR   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_STRETCH = 4'd2;
    localparam logic [MODE_W-1:0] MODE_CURL    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIV     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ROT     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ANNULUS = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DIST2   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DIST3   = 4'd8;

    // q30 constants
    localparam logic [63:0] C_ONE         = 64'd1073741824;
    localparam logic [63:0] C_HALF        = 64'd536870912;
    localparam logic [63:0] C_TENTH       = 64'd107374182;
    localparam logic [63:0] C_NINE_TENTHS = 64'd966367642;
    localparam logic [63:0] C_EPS2        = 64'd53687091;
    localparam logic [63:0] C_EPS3        = 64'd10737418;

    // taylor coefficients of sin(pi u / 2), q30
    localparam logic [63:0] POLY_C [5] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272
    };

    typedef struct packed {
        logic                valid;
        logic [MODE_W-1:0]   mode;
    } t_ctl;

    function automatic logic [63:0] umulq(logic [63:0] a, logic [63:0] b);
        return (a * b + (64'd1 << (Q_BITS - 1))) >> Q_BITS;
    endfunction

    // quarter-wave sine value for table entry i, q30
    function automatic logic [Q_BITS:0] quarter_sine(int i, int stb);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] acc;
        u   = 64'(i) << (Q_BITS - stb);
        u2  = umulq(u, u);
        acc = POLY_C[3] - umulq(u2, POLY_C[4]);
        acc = POLY_C[2] - umulq(u2, acc);
        acc = POLY_C[1] - umulq(u2, acc);
        acc = POLY_C[0] - umulq(u2, acc);
        return (Q_BITS + 1)'(umulq(u, acc));
    endfunction

endpackage

// ===== rtl/rcm_sine_rom.sv =====
// quarter-wave sine table with quadrant folding and registered read
module rcm_sine_rom import rcm_pkg::*; #(
    parameter int STB = SINE_TABLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [STB+1:0]           i_phase,
    output logic signed [Q_BITS+1:0] o_sine
);

    localparam int N = 1 << STB;

    logic [Q_BITS:0] rom [N+1];
    logic [1:0]      quad;
    logic [STB-1:0]  idx;
    logic [STB:0]    addr;
    logic [Q_BITS:0] r_mag;
    logic            r_neg;

    for (genvar g = 0; g <= N; g++) begin : g_tab
        assign rom[g] = quarter_sine(g, STB);
    end

    assign quad = i_phase[STB+1:STB];
    assign idx  = i_phase[STB-1:0];
    // odd quadrants mirror the index
    assign addr = quad[0] ? ((STB+1)'(N) - {1'b0, idx}) : {1'b0, idx};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= rom[addr];
            r_neg <= quad[1];
        end
    end

    assign o_sine = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

endmodule

// ===== rtl/rcm_mul_cell.sv =====
// one cell of the multiply chain: two rounding q30 multiplier lanes with bypass
module rcm_mul_cell import rcm_pkg::*; #(
    parameter int STAGE = 0,
    parameter int VW    = 34,
    parameter int SW    = Q_BITS + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_ctl                 i_ctl,
    input  logic signed [VW-1:0] i_r,
    input  logic signed [VW-1:0] i_s,
    input  logic signed [VW-1:0] i_t,
    input  logic signed [SW-1:0] i_v0,
    input  logic signed [SW-1:0] i_v1,
    input  logic signed [SW-1:0] i_v2,
    input  logic signed [VW-1:0] i_p0,
    input  logic signed [VW-1:0] i_p1,
    output t_ctl                 o_ctl,
    output logic signed [VW-1:0] o_r,
    output logic signed [VW-1:0] o_s,
    output logic signed [VW-1:0] o_t,
    output logic signed [SW-1:0] o_v0,
    output logic signed [SW-1:0] o_v1,
    output logic signed [SW-1:0] o_v2,
    output logic signed [VW-1:0] o_p0,
    output logic signed [VW-1:0] o_p1
);

    localparam int PW = VW + SW;

    t_ctl                 r_ctl;
    logic signed [VW-1:0] r_r, r_s, r_t, r_p0, r_p1;
    logic signed [SW-1:0] r_v0, r_v1, r_v2;
    logic                 use0, use1;
    logic signed [VW-1:0] a0, a1;
    logic signed [SW-1:0] b0, b1;

    // product rounded half away from zero back to q30
    function automatic logic signed [VW-1:0] mulq(logic signed [VW-1:0] a,
                                                  logic signed [SW-1:0] b);
        logic signed [PW-1:0] p;
        logic [PW-1:0]        m;
        p = PW'(a) * PW'(b);
        m = p[PW-1] ? PW'(-p) : PW'(p);
        m = (m + (PW'(1) << (Q_BITS - 1))) >> Q_BITS;
        return p[PW-1] ? VW'(-m) : VW'(m);
    endfunction

    always_comb begin
        use0 = 1'b0;
        use1 = 1'b0;
        a0   = i_r;
        b0   = SW'(C_ONE);
        a1   = i_r;
        b1   = SW'(C_ONE);
        case (STAGE)
            0: begin
                if (i_ctl.mode == MODE_ANNULUS) begin
                    use0 = 1'b1;
                    b0   = SW'(C_NINE_TENTHS);
                end
            end
            1: begin
                case (i_ctl.mode) inside
                    MODE_POLAR: begin
                        use0 = 1'b1;
                        use1 = 1'b1;
                        a0   = i_r + VW'(C_HALF);
                        b0   = i_v0;
                        a1   = i_r + VW'(C_HALF);
                        b1   = i_v1;
                    end
                    MODE_ANNULUS: begin
                        use0 = 1'b1;
                        use1 = 1'b1;
                        a0   = i_p0 + VW'(C_TENTH);
                        b0   = i_v0;
                        a1   = i_p0 + VW'(C_TENTH);
                        b1   = i_v1;
                    end
                    MODE_DIST2, MODE_DIST3: begin
                        use0 = 1'b1;
                        a0   = VW'(i_v0);
                        b0   = i_v1;
                    end
                    default: ;
                endcase
            end
            2: begin
                if (i_ctl.mode == MODE_DIST2) begin
                    use0 = 1'b1;
                    a0   = i_p0;
                    b0   = SW'(C_EPS2);
                end else if (i_ctl.mode == MODE_DIST3) begin
                    use0 = 1'b1;
                    a0   = i_p0;
                    b0   = i_v2;
                end
            end
            3: begin
                if (i_ctl.mode == MODE_DIST3) begin
                    use0 = 1'b1;
                    a0   = i_p0;
                    b0   = SW'(C_EPS3);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
            r_ctl.mode  <= i_ctl.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r        <= i_r;
            r_s        <= i_s;
            r_t        <= i_t;
            r_v0       <= i_v0;
            r_v1       <= i_v1;
            r_v2       <= i_v2;
            r_p0       <= use0 ? mulq(a0, b0) : i_p0;
            r_p1       <= use1 ? mulq(a1, b1) : i_p1;
        end
    end

    assign o_ctl = r_ctl;
    assign o_r   = r_r;
    assign o_s   = r_s;
    assign o_t   = r_t;
    assign o_v0  = r_v0;
    assign o_v1  = r_v1;
    assign o_v2  = r_v2;
    assign o_p0  = r_p0;
    assign o_p1  = r_p1;

endmodule

// ===== rtl/reference_coordinate_mapper.sv =====
// top level of the reference coordinate mapper: phase stage, sine tables, cell chain, output
//
// maps a reference point (r,s,t), unsigned q1.16, to physical (x,y,z), signed q2.16
// saturated to +-2.0, under the mode held in the configuration register (identity,
// polar, sine stretch, curl, div, rotation, half annulus, 2d and 3d sine distortion;
// codes 9 to 15 act as identity, 2d modes pass t through as z). one point enters per
// clock while s_axis_tready is high; its result passes a phase register, the sine
// table read running beside the first multiply cell, three more multiply cells and the
// output register. the whole pipeline advances as one; a skid register behind the output
// register keeps s_axis_tready high while a result waits to be taken, so only a stall
// lasting two results holds the input back. the mode is sampled with each point, so a
// write to it while points are in flight does not disturb them.
module reference_coordinate_mapper import rcm_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input point transfer
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // ref_r, ref_s, ref_t, zero fill
    // result transfer
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // phys_x, phys_y, phys_z, zero fill
    // mode register write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MODE_W-1:0]      cfg_data        // map_mode
);

    // value width: q30 copy of a full 17 bit input times three, never below the constants
    localparam int VW_RAW = IN_W + Q_BITS - FRAC_BITS + 3;
    localparam int VW     = (VW_RAW > 34) ? VW_RAW : 34;
    localparam int SW     = Q_BITS + 2;
    localparam int PB     = SINE_TABLE_BITS + 2;
    localparam int RS     = Q_BITS - FRAC_BITS;
    localparam logic [VW-1:0] RND_OUT = VW'((64'd1 << RS) >> 1);
    localparam logic [PB-1:0] QTR     = PB'(1) << SINE_TABLE_BITS;

    // mode register
    logic [MODE_W-1:0] r_mode;

    // input fields
    logic [IN_W-1:0] in_r, in_s, in_t;

    // phase indexes of the input angles
    logic [PB-1:0] ph_r0, ph_r2, ph_s0, ph_s1, ph_s2, ph_t0, ph_t2;
    logic [PB-1:0] n_ph0, n_ph1, n_ph2;
    logic [PB-1:0] r_ph0, r_ph1, r_ph2;

    // pipeline enable, held only while the skid register is full
    logic en;

    // chain signals: index 0 is the phase stage, index k+1 the output of cell k
    t_ctl                 c_ctl [5];
    logic signed [VW-1:0] c_r   [5];
    logic signed [VW-1:0] c_s   [5];
    logic signed [VW-1:0] c_t   [5];
    logic signed [SW-1:0] c_v0  [5];
    logic signed [SW-1:0] c_v1  [5];
    logic signed [SW-1:0] c_v2  [5];
    logic signed [VW-1:0] c_p0  [5];
    logic signed [VW-1:0] c_p1  [5];
    logic signed [SW-1:0] in_v0 [4];
    logic signed [SW-1:0] in_v1 [4];
    logic signed [SW-1:0] in_v2 [4];

    // sine table outputs, aligned with the first cell's output
    logic signed [SW-1:0] sin0, sin1, sin2;

    // phase stage registers
    t_ctl                 r_a_ctl;
    logic signed [VW-1:0] r_a_r, r_a_s, r_a_t;

    // result assembly and output buffering
    logic signed [VW-1:0] fx, fy, fz;
    logic [3*OUT_W-1:0]   n_res;
    logic [3*OUT_W-1:0]   r_out, r_skid;
    logic                 r_ov, r_sv;
    logic                 take;

    function automatic logic [PB-1:0] phase_of(logic [IN_W-1:0] v, int extra);
        int          d;
        logic [63:0] w;
        d = FRAC_BITS + extra - PB;
        w = 64'(v);
        if (d > 0) begin
            w = (w + ((64'd1 << d) >> 1)) >> d;
        end else begin
            w = w << (-d);
        end
        return w[PB-1:0];
    endfunction

    // q30 to output format, rounded half away from zero and saturated
    function automatic logic [OUT_W-1:0] to_out(logic signed [VW-1:0] v);
        logic [VW-1:0]      m;
        logic signed [VW:0] o;
        logic signed [VW:0] lim;
        lim = (VW+1)'(64'd2 << FRAC_BITS);
        m   = v[VW-1] ? VW'(-v) : VW'(v);
        m   = (m + RND_OUT) >> RS;
        o   = v[VW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        if (o > lim) begin
            o = lim;
        end
        if (o < -lim) begin
            o = -lim;
        end
        return o[OUT_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDENT;
        end else if (cfg_valid) begin
            r_mode <= cfg_data;
        end
    end

    assign in_r = s_axis_tdata[IN_W-1:0];
    assign in_s = s_axis_tdata[2*IN_W-1:IN_W];
    assign in_t = s_axis_tdata[3*IN_W-1:2*IN_W];

    assign ph_r0 = phase_of(in_r, 0);
    assign ph_r2 = phase_of(in_r, 2);
    assign ph_s0 = phase_of(in_s, 0);
    assign ph_s1 = phase_of(in_s, 1);
    assign ph_s2 = phase_of(in_s, 2);
    assign ph_t0 = phase_of(in_t, 0);
    assign ph_t2 = phase_of(in_t, 2);

    // table 0 feeds x, table 1 feeds y, table 2 only the t sine; cosine is a quarter ahead
    always_comb begin
        n_ph0 = ph_r0;
        n_ph1 = ph_s0;
        n_ph2 = ph_t0;
        case (r_mode)
            MODE_POLAR: begin
                n_ph0 = ph_s0 + QTR;
            end
            MODE_STRETCH: begin
                n_ph0 = ph_r2;
                n_ph1 = ph_s2;
                n_ph2 = ph_t2;
            end
            MODE_ANNULUS: begin
                n_ph0 = ph_s1;
                n_ph1 = ph_s1 + QTR;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = en;
    assign en            = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
        end else if (en) begin
            r_a_ctl.valid <= s_axis_tvalid;
            r_a_ctl.mode  <= r_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_r        <= VW'(in_r) << RS;
            r_a_s        <= VW'(in_s) << RS;
            r_a_t        <= VW'(in_t) << RS;
            r_ph0        <= n_ph0;
            r_ph1        <= n_ph1;
            r_ph2        <= n_ph2;
        end
    end

    rcm_sine_rom #(.STB(SINE_TABLE_BITS)) u_sin0 (
        .i_clk(i_clk), .i_en(en), .i_phase(r_ph0), .o_sine(sin0)
    );
    rcm_sine_rom #(.STB(SINE_TABLE_BITS)) u_sin1 (
        .i_clk(i_clk), .i_en(en), .i_phase(r_ph1), .o_sine(sin1)
    );
    rcm_sine_rom #(.STB(SINE_TABLE_BITS)) u_sin2 (
        .i_clk(i_clk), .i_en(en), .i_phase(r_ph2), .o_sine(sin2)
    );

    assign c_ctl[0] = r_a_ctl;
    assign c_r[0]   = r_a_r;
    assign c_s[0]   = r_a_s;
    assign c_t[0]   = r_a_t;
    assign c_v0[0]  = '0;
    assign c_v1[0]  = '0;
    assign c_v2[0]  = '0;
    assign c_p0[0]  = '0;
    assign c_p1[0]  = '0;

    // the sine values join the chain behind the first cell
    for (genvar g = 0; g < 4; g++) begin : g_chain
        if (g == 1) begin : g_join
            assign in_v0[g] = sin0;
            assign in_v1[g] = sin1;
            assign in_v2[g] = sin2;
        end else begin : g_pass
            assign in_v0[g] = c_v0[g];
            assign in_v1[g] = c_v1[g];
            assign in_v2[g] = c_v2[g];
        end

        rcm_mul_cell #(.STAGE(g), .VW(VW), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[g]),
            .i_r     (c_r[g]),
            .i_s     (c_s[g]),
            .i_t     (c_t[g]),
            .i_v0    (in_v0[g]),
            .i_v1    (in_v1[g]),
            .i_v2    (in_v2[g]),
            .i_p0    (c_p0[g]),
            .i_p1    (c_p1[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_r     (c_r[g+1]),
            .o_s     (c_s[g+1]),
            .o_t     (c_t[g+1]),
            .o_v0    (c_v0[g+1]),
            .o_v1    (c_v1[g+1]),
            .o_v2    (c_v2[g+1]),
            .o_p0    (c_p0[g+1]),
            .o_p1    (c_p1[g+1])
        );
    end

    // final coordinates in q30; p0 carries the product or the distortion term
    always_comb begin
        fx = c_r[4];
        fy = c_s[4];
        fz = c_t[4];
        case (c_ctl[4].mode) inside
            MODE_POLAR, MODE_ANNULUS: begin
                fx = c_p0[4];
                fy = c_p1[4];
            end
            MODE_STRETCH: begin
                fx = VW'(c_v0[4]);
                fy = VW'(c_v1[4]);
                fz = VW'(c_v2[4]);
            end
            MODE_CURL: begin
                fx = VW'(C_ONE) - c_s[4];
                fy = c_r[4];
            end
            MODE_DIV: begin
                fx = (c_r[4] <<< 1) + c_r[4] - VW'(C_ONE);
                fy = (c_s[4] <<< 1) + c_s[4] - VW'(C_ONE);
            end
            MODE_ROT: begin
                fx = c_r[4] - c_s[4];
                fy = c_r[4] + c_s[4] - VW'(C_ONE);
            end
            MODE_DIST2: begin
                fx = c_r[4] + c_p0[4];
                fy = c_s[4] + c_p0[4];
            end
            MODE_DIST3: begin
                fx = c_r[4] + c_p0[4];
                fy = c_s[4] + c_p0[4];
                fz = c_t[4] + c_p0[4];
            end
            default: ;
        endcase
    end

    assign n_res = {to_out(fz), to_out(fy), to_out(fx)};

    // output register with skid stage behind it
    assign take = r_ov && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_sv <= 1'b0;
            end
        end else if (c_ctl[4].valid) begin
            if (!r_ov || take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (c_ctl[4].valid) begin
            if (!r_ov || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {(OUT_TDATA_W - 3*OUT_W)'(0), r_out};

endmodule
